// ===== design/trrc_pkg.sv =====
// package with the shared types and codes of the read receive controller
`timescale 1ns / 1ps
`default_nettype none
package trrc_pkg;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_PACKET  = 2'd1;
    localparam logic [1:0] ACT_EMPTY   = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;

    localparam logic [1:0] SEND_NONE     = 2'd0;
    localparam logic [1:0] SEND_RRQ      = 2'd1;
    localparam logic [1:0] SEND_ACK      = 2'd2;
    localparam logic [1:0] SEND_DISKFULL = 2'd3;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_SERVER  = 3'd2;
    localparam logic [2:0] ST_SINK    = 3'd3;
    localparam logic [2:0] ST_RETRIES = 3'd4;

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_RUN  = 1'b1;

    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [15:0] payload_length;
        logic        sink_accepted;
    } t_event;

    typedef struct packed {
        logic [15:0] last_block;
        logic [3:0]  retries_left;
        logic        phase;
    } t_state;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_block;
        logic        deliver;
        logic [2:0]  status;
    } t_result;

endpackage
`default_nettype wire

// ===== design/trrc_step.sv =====
// one transfer step: next state and result word from one event and the current state
`timescale 1ns / 1ps
`default_nettype none
module trrc_step
    import trrc_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input  wire t_event     i_event,
    input  wire t_state     i_state,
    input  wire logic [3:0] i_retry_limit,
    output t_state          o_state,
    output t_result         o_result
);

    localparam logic [15:0] BLOCK_LEN = BLOCK_BYTES[15:0];

    logic        ended;
    logic        final_block;
    logic        dlv;
    logic [3:0]  ret_dec;
    logic [15:0] next_block;

    assign ret_dec    = (i_state.retries_left != 4'd0) ? (i_state.retries_left - 4'd1) : 4'd0;
    assign next_block = i_state.last_block + 16'd1;

    always_comb begin
        o_state     = i_state;
        o_result    = '0;
        ended       = 1'b0;
        final_block = 1'b0;
        dlv         = 1'b0;
        if (i_event.action == ACT_START) begin
            o_state.last_block   = 16'd0;
            o_state.retries_left = i_retry_limit;
            o_state.phase        = PH_RUN;
            o_result.send_kind   = SEND_RRQ;
        end else if (i_state.phase == PH_RUN) begin
            if (i_event.action == ACT_PACKET) begin
                if (i_event.opcode == OP_DATA) begin
                    if (i_event.block_number == next_block) begin
                        o_state.last_block   = i_event.block_number;
                        o_state.retries_left = i_retry_limit;
                        dlv                  = 1'b1;
                        if (!i_event.sink_accepted) begin
                            // sink refusal wins over every other failure
                            o_state.phase      = PH_IDLE;
                            o_result.send_kind = SEND_DISKFULL;
                            o_result.deliver   = 1'b1;
                            o_result.status    = ST_SINK;
                            ended              = 1'b1;
                        end else begin
                            final_block = (i_event.payload_length != BLOCK_LEN);
                        end
                    end else begin
                        o_state.retries_left = ret_dec;
                    end
                end else if (i_event.opcode == OP_ERROR) begin
                    o_state.phase   = PH_IDLE;
                    o_result.status = ST_SERVER;
                    ended           = 1'b1;
                end
            end else if (i_event.action == ACT_TIMEOUT) begin
                o_state.retries_left = ret_dec;
            end

            if (!ended) begin
                o_result.deliver = dlv;
                if (o_state.retries_left == 4'd0) begin
                    o_state.phase   = PH_IDLE;
                    o_result.status = ST_RETRIES;
                end else begin
                    if (final_block) begin
                        o_state.phase = PH_IDLE;
                    end
                    // block zero means no data yet: ask for the file again
                    if (o_state.last_block == 16'd0) begin
                        o_result.send_kind = SEND_RRQ;
                    end else begin
                        o_result.send_kind  = SEND_ACK;
                        o_result.send_block = o_state.last_block;
                    end
                    o_result.status = final_block ? ST_DONE : ST_RUN;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/tftp_read_receive_control.sv =====
// top level of the read receive controller: event register, step logic, result register
// Usage:
// - event channel (i_in_valid / o_in_stall) carries one event word: start,
//   received packet (opcode, block number, payload length, sink verdict),
//   empty datagram or receive timeout.
// - result channel (o_out_valid / i_out_stall) gives exactly one word per
//   event: packet to send, block number to acknowledge, deliver flag, status.
// - i_cfg_we / i_cfg_data write the retry limit; write it only while idle.
// The accepted event is held in the event register, then the step is evaluated
// from it and the transfer state into the result register, which waits while a
// pending result is stalled. Throughput is one event per cycle while no result
// is stalled; the state update is a loop through compares and the retry counter.
// Reset clears both registers' valid bits, puts the transfer in idle with
// block zero and no retries, and sets the retry limit to 5.
// While i_out_stall holds a pending result, the event register keeps its
// word and o_in_stall rises once it is full; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module tftp_read_receive_control
    import trrc_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_opcode,
    input  wire logic [15:0] i_block_number,
    input  wire logic [15:0] i_payload_length,
    input  wire logic        i_sink_accepted,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_send_kind,
    output logic [15:0]      o_send_block,
    output logic             o_deliver,
    output logic [2:0]       o_status
);

    logic [3:0] r_retry_limit;
    logic       r_ev_valid;
    t_event     r_ev;
    t_state     r_state;
    logic       r_out_valid;
    t_result    r_out;

    t_state     n_state;
    t_result    n_out;
    logic       out_free;
    logic       step_go;
    logic       ev_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_go    = r_ev_valid && out_free;
    assign o_in_stall = r_ev_valid && !out_free;
    assign ev_take    = i_in_valid && !o_in_stall;

    trrc_step #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_step (
        .i_event      (r_ev),
        .i_state      (r_state),
        .i_retry_limit(r_retry_limit),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_retry_limit <= i_cfg_data;
        end
    end

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (ev_take) begin
            r_ev_valid <= 1'b1;
        end else if (step_go) begin
            r_ev_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_take) begin
            r_ev.action         <= i_action;
            r_ev.opcode         <= i_opcode;
            r_ev.block_number   <= i_block_number;
            r_ev.payload_length <= i_payload_length;
            r_ev.sink_accepted  <= i_sink_accepted;
        end
    end

    // transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_block   <= 16'd0;
            r_state.retries_left <= 4'd0;
            r_state.phase        <= PH_IDLE;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_send_kind  = r_out.send_kind;
    assign o_send_block = r_out.send_block;
    assign o_deliver    = r_out.deliver;
    assign o_status     = r_out.status;

endmodule
`default_nettype wire

// ===== dv/tb_tftp_read_receive_control.sv =====
// testbench for the read receive controller: directed and random events, checked against a predictor
`timescale 1ns / 1ps
module tb_tftp_read_receive_control;
    import trrc_pkg::*;

    localparam int BLOCK_BYTES = 512;
    localparam logic [15:0] BLOCK_LEN = 16'(BLOCK_BYTES);
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 6;
    localparam int EVENTS_PER_PHASE = 280;
    localparam int RUN_BLOCKS = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [15:0] i_opcode;
    logic [15:0] i_block_number;
    logic [15:0] i_payload_length;
    logic        i_sink_accepted;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_send_kind;
    logic [15:0] o_send_block;
    logic        o_deliver;
    logic [2:0]  o_status;

    // predictor copy of the transfer state and the retry limit
    logic [15:0] xfer_block;
    logic [3:0]  xfer_retries;
    logic        xfer_phase;
    logic [3:0]  retry_limit;

    t_result expected_results[$];
    int fail_count;
    int events_sent;
    int words_checked;
    int status_count[8];
    int cycle_count;
    bit no_idling;

    tftp_read_receive_control #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_action(i_action),
        .i_opcode(i_opcode),
        .i_block_number(i_block_number),
        .i_payload_length(i_payload_length),
        .i_sink_accepted(i_sink_accepted),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_send_kind(o_send_kind),
        .o_send_block(o_send_block),
        .o_deliver(o_deliver),
        .o_status(o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic t_event make_event(input logic [1:0] act, input logic [15:0] op,
                                          input logic [15:0] blk, input logic [15:0] len,
                                          input logic sink);
        t_event ev;
        ev.action = act;
        ev.opcode = op;
        ev.block_number = blk;
        ev.payload_length = len;
        ev.sink_accepted = sink;
        return ev;
    endfunction

    function automatic void drop_retry();
        if (xfer_retries != 4'd0)
            xfer_retries = xfer_retries - 4'd1;
    endfunction

    // next transfer step: updates the predicted state and returns the word it answers with
    function automatic t_result transfer_step(input t_event ev);
        t_result r;
        logic [15:0] next_blk;
        logic last_one;
        logic dlv;
        r = '0;
        last_one = 1'b0;
        dlv = 1'b0;
        next_blk = xfer_block + 16'd1;
        if (ev.action == ACT_START) begin
            xfer_block = 16'd0;
            xfer_retries = retry_limit;
            xfer_phase = PH_RUN;
            r.send_kind = SEND_RRQ;
            return r;
        end
        if (xfer_phase != PH_RUN)
            return r;
        if (ev.action == ACT_PACKET) begin
            if (ev.opcode == OP_DATA) begin
                if (ev.block_number == next_blk) begin
                    xfer_block = next_blk;
                    xfer_retries = retry_limit;
                    dlv = 1'b1;
                    if (!ev.sink_accepted) begin
                        xfer_phase = PH_IDLE;
                        r.send_kind = SEND_DISKFULL;
                        r.deliver = 1'b1;
                        r.status = ST_SINK;
                        return r;
                    end
                    last_one = (ev.payload_length != BLOCK_LEN);
                end else begin
                    drop_retry();
                end
            end else if (ev.opcode == OP_ERROR) begin
                xfer_phase = PH_IDLE;
                r.status = ST_SERVER;
                return r;
            end
        end else if (ev.action == ACT_TIMEOUT) begin
            drop_retry();
        end
        r.deliver = dlv;
        if (xfer_retries == 4'd0) begin
            xfer_phase = PH_IDLE;
            r.status = ST_RETRIES;
            return r;
        end
        if (last_one)
            xfer_phase = PH_IDLE;
        r.status = last_one ? ST_DONE : ST_RUN;
        if (xfer_block == 16'd0) begin
            r.send_kind = SEND_RRQ;
        end else begin
            r.send_kind = SEND_ACK;
            r.send_block = xfer_block;
        end
        return r;
    endfunction

    // one event word: optional idle gap, then hold it until accepted
    task automatic send_event(input t_event ev);
        int gap;
        gap = no_idling ? 0 : $urandom_range(4);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_action = ev.action;
        i_opcode = ev.opcode;
        i_block_number = ev.block_number;
        i_payload_length = ev.payload_length;
        i_sink_accepted = ev.sink_accepted;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(transfer_step(ev));
        events_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk) i_in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_retry_limit(input logic [3:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk) i_cfg_we = 1'b0;
        retry_limit = value;
    endtask

    // receiver side: a random stall before each word
    initial begin : out_stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = no_idling ? 0 : $urandom_range(4);
            if (n > 0) begin
                @(negedge i_clk) i_out_stall = 1'b1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk) i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("word with none expected, status", o_status, -1);
            end else begin
                want = expected_results.pop_front();
                words_checked++;
                status_count[want.status]++;
                if (o_send_kind !== want.send_kind)
                    report_mismatch("send_kind", o_send_kind, want.send_kind);
                if (o_send_block !== want.send_block)
                    report_mismatch("send_block", o_send_block, want.send_block);
                if (o_deliver !== want.deliver)
                    report_mismatch("deliver", o_deliver, want.deliver);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    // events before any start are ignored
    task automatic test_idle_events();
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd1, BLOCK_LEN, 1'b1));
        send_event(make_event(ACT_PACKET, OP_ERROR, 16'hFFFF, 16'hFFFF, 1'b0));
        send_event(make_event(ACT_EMPTY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_event(make_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0, 1'b0));
    endtask

    // reset retry limit of five, spent by timeouts and wrong blocks only
    task automatic test_default_retry_limit();
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_TIMEOUT, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_EMPTY, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_PACKET, 16'hFFFF, 16'd1, BLOCK_LEN, 1'b1));
        send_event(make_event(ACT_PACKET, OP_DATA, 16'hFFFF, BLOCK_LEN, 1'b1));
        repeat (3) send_event(make_event(ACT_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    endtask

    task automatic test_transfer_endings();
        write_retry_limit(4'd15);
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd1, BLOCK_LEN, 1'b1));
        // duplicate block costs a retry and repeats the ack
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd1, BLOCK_LEN, 1'b1));
        // restart in mid transfer
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b1));
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd1, BLOCK_LEN, 1'b1));
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd2, 16'd0, 1'b1));
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd1, 16'hFFFF, 1'b1));
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd1, BLOCK_LEN, 1'b0));
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_PACKET, OP_ERROR, 16'd1, BLOCK_LEN, 1'b1));
    endtask

    // a limit of zero fails on the first event after start, even on a good block
    task automatic test_retry_limit_zero();
        write_retry_limit(4'd0);
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_EMPTY, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        send_event(make_event(ACT_PACKET, OP_DATA, 16'd1, BLOCK_LEN, 1'b1));
    endtask

    // long in-order run of full blocks back to back, closed by a short block
    task automatic test_block_wrap();
        logic [15:0] blk;
        write_retry_limit(4'd3);
        no_idling = 1'b1;
        send_event(make_event(ACT_START, 16'd0, 16'd0, 16'd0, 1'b0));
        blk = 16'd1;
        repeat (RUN_BLOCKS) begin
            send_event(make_event(ACT_PACKET, OP_DATA, blk, BLOCK_LEN, 1'b1));
            blk = blk + 16'd1;
        end
        send_event(make_event(ACT_PACKET, OP_DATA, blk, 16'd7, 1'b1));
        no_idling = 1'b0;
    endtask

    // mostly in-order transfers with random faults, some pure noise
    function automatic t_event pick_event();
        t_event ev;
        int roll;
        ev.action = 2'($urandom_range(3));
        ev.opcode = 16'($urandom_range(65535));
        ev.block_number = 16'($urandom_range(65535));
        ev.payload_length = 16'($urandom_range(65535));
        ev.sink_accepted = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if ((xfer_phase == PH_IDLE && roll < 75) || roll < 3) begin
            ev.action = ACT_START;
        end else if (roll < 60) begin
            ev.action = ACT_PACKET;
            ev.opcode = OP_DATA;
            ev.block_number = xfer_block + 16'd1;
            ev.payload_length = BLOCK_LEN;
            ev.sink_accepted = 1'b1;
            if ($urandom_range(19) == 0)
                ev.payload_length = 16'($urandom_range(65535));
            if ($urandom_range(49) == 0)
                ev.sink_accepted = 1'b0;
        end else if (roll < 68) begin
            ev.action = ACT_PACKET;
            ev.opcode = OP_DATA;
            if ($urandom_range(1) == 0)
                ev.block_number = xfer_block;
        end else if (roll < 75) begin
            ev.action = ACT_TIMEOUT;
        end else if (roll < 80) begin
            ev.action = ACT_EMPTY;
        end else if (roll < 83) begin
            ev.action = ACT_PACKET;
            ev.opcode = OP_ERROR;
        end else if (roll < 88) begin
            ev.action = ACT_PACKET;
        end
        return ev;
    endfunction

    task automatic test_random_transfers();
        logic [3:0] limits[RANDOM_PHASES];
        t_event ev;
        int counted;
        bit live;
        limits = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 14)), 4'($urandom_range(1, 15)),
                   4'd15};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_retry_limit(limits[p]);
            no_idling = (p % 3 == 1);
            counted = 0;
            while (counted < EVENTS_PER_PHASE) begin
                ev = pick_event();
                live = (xfer_phase == PH_RUN) || (ev.action == ACT_START);
                send_event(ev);
                if (live)
                    counted++;
            end
        end
        no_idling = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 4'd0;
        i_in_valid = 1'b0;
        i_action = ACT_START;
        i_opcode = 16'd0;
        i_block_number = 16'd0;
        i_payload_length = 16'd0;
        i_sink_accepted = 1'b0;
        fail_count = 0;
        events_sent = 0;
        words_checked = 0;
        cycle_count = 0;
        no_idling = 1'b0;
        foreach (status_count[k]) status_count[k] = 0;
        xfer_block = 16'd0;
        xfer_retries = 4'd0;
        xfer_phase = PH_IDLE;
        retry_limit = RETRY_LIMIT_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        test_idle_events();
        test_default_retry_limit();
        test_transfer_endings();
        test_retry_limit_zero();
        test_block_wrap();
        test_random_transfers();

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("%0d events sent, %0d result words checked, incl. a long in-order block run",
                 events_sent, words_checked);
        $display("transfers ended: %0d done, %0d server error, %0d sink refused, %0d no retries",
                 status_count[ST_DONE], status_count[ST_SERVER], status_count[ST_SINK],
                 status_count[ST_RETRIES]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
